/* src/assert_macros.svh */
// Assertion macros for the RTL of the integer-to-text block.
// Needs nothing else; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define RITA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked on every rising clock edge, reset included.
`define RITA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

/* src/rita_pkg.sv */
// Package for the integer-to-text block: widths, character codes and helpers.
// Used by the channel interfaces and the top level; depends on nothing.
package rita_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int BIT_W       = $clog2(VALUE_WIDTH);
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 8;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [0:0] REG_RADIX = 1'b0;

    localparam logic [RADIX_W-1:0] RADIX_MIN      = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX      = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET    = 6'd10;
    localparam logic [RADIX_W-1:0] DECIMAL_DIGITS = 6'd10;

    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

    typedef logic [RADIX_W-1:0] t_digit;

    function automatic t_digit clamp_radix(input t_digit r);
        if (r < RADIX_MIN) begin
            return RADIX_MIN;
        end
        if (r > RADIX_MAX) begin
            return RADIX_MAX;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input t_digit d);
        logic [CHAR_W-1:0] w;
        w = {{(CHAR_W - RADIX_W){1'b0}}, d};
        if (d >= DECIMAL_DIGITS) begin
            return w - {{(CHAR_W - RADIX_W){1'b0}}, DECIMAL_DIGITS} + CH_LOWER_A;
        end
        return w + CH_ZERO;
    endfunction

endpackage

/* src/rita_if.sv */
// Valid/ready channel interfaces: value items in, character items out.
// Depends on rita_pkg for the field widths.
interface rita_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [rita_pkg::VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rita_out_if;
    logic                          valid;
    logic                          ready;
    logic [rita_pkg::CHAR_W-1:0]   character;
    logic                          last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

/* src/radix_integer_to_ascii.sv */
// Top level: signed integer to text in a programmable radix, bit-serial divider.
// Depends on rita_pkg, the channels in rita_if.sv and assert_macros.svh.
//
// Use: write the radix (2..36, reset 10) at address 0 of the APB port while
// idle; its low six bits are kept, 0 or 1 acting as 2 and above 36 as 36.
// Send one signed value per item on i_value_ch. The text comes out on
// o_char_ch one character per item, most significant first, '-' leading a
// negative value, last set on the final one. Digits are split off by a
// restoring divider that shifts the magnitude one bit per cycle; the digits
// wait on a 32-deep shift-register stack until the last one is found.
// A new value is taken as soon as the final character sits in the output
// register, even if it is not yet taken. A stalled receiver only holds the
// character stream; nothing is dropped. Reset (synchronous, active low)
// empties the block and sets radix to 10.
`include "assert_macros.svh"

module radix_integer_to_ascii (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rita_in_if.sink                       i_value_ch,
    rita_out_if.source                    o_char_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rita_pkg::ADDR_W-1:0]   paddr,
    input  logic [rita_pkg::DATA_W-1:0]   pwdata,
    output logic [rita_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int VW    = rita_pkg::VALUE_WIDTH;
    localparam int BIT_W = rita_pkg::BIT_W;
    localparam int CNT_W = rita_pkg::CNT_W;
    localparam int RW    = rita_pkg::RADIX_W;
    localparam int CW    = rita_pkg::CHAR_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]              r_state,     n_state;
    rita_pkg::t_digit        r_radix,     n_radix;
    rita_pkg::t_digit        r_radix_eff, n_radix_eff;
    logic [VW-1:0]           r_mag,       n_mag;
    rita_pkg::t_digit        r_rem,       n_rem;
    logic [BIT_W-1:0]        r_bit,       n_bit;
    logic [CNT_W-1:0]        r_count,     n_count;
    logic                    r_neg,       n_neg;
    rita_pkg::t_digit        r_stack [VW];
    rita_pkg::t_digit        n_stack [VW];
    logic                    r_out_valid, n_out_valid;
    logic [CW-1:0]           r_out_char,  n_out_char;
    logic                    r_out_last,  n_out_last;

    logic                    w_in_acc;
    logic                    w_slot;
    logic                    w_cfg_wr;
    logic [RW:0]             w_trial;
    logic [RW:0]             w_diff;
    logic                    w_ge;
    rita_pkg::t_digit        w_rem_next;
    logic [VW-1:0]           w_mag_next;

    assign i_value_ch.ready = (r_state == S_IDLE);
    assign w_in_acc         = i_value_ch.valid && (r_state == S_IDLE);
    assign w_slot           = !r_out_valid || o_char_ch.ready;

    assign o_char_ch.valid     = r_out_valid;
    assign o_char_ch.character = r_out_char;
    assign o_char_ch.last      = r_out_last;

    // APB register file: only the radix
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == rita_pkg::REG_RADIX);
    assign prdata   = (paddr[2] == rita_pkg::REG_RADIX)
                    ? {{(rita_pkg::DATA_W - RW){1'b0}}, r_radix}
                    : '0;

    // one restoring division step
    assign w_trial    = {r_rem, r_mag[VW-1]};
    assign w_ge       = (w_trial >= {1'b0, r_radix_eff});
    assign w_diff     = w_trial - {1'b0, r_radix_eff};
    assign w_rem_next = w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];
    assign w_mag_next = {r_mag[VW-2:0], w_ge};

    always_comb begin
        n_state     = r_state;
        n_radix     = w_cfg_wr ? pwdata[RW-1:0] : r_radix;
        n_radix_eff = r_radix_eff;
        n_mag       = r_mag;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_count     = r_count;
        n_neg       = r_neg;
        n_stack     = r_stack;
        n_out_valid = r_out_valid && !o_char_ch.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_neg       = i_value_ch.value[VW-1];
                    n_mag       = i_value_ch.value[VW-1]
                                ? (~i_value_ch.value + 1'b1)
                                : i_value_ch.value;
                    n_radix_eff = rita_pkg::clamp_radix(r_radix);
                    n_rem       = '0;
                    n_bit       = '0;
                    n_count     = '0;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                n_mag = w_mag_next;
                if (r_bit == BIT_W'(VW - 1)) begin
                    n_stack[0] = w_rem_next;
                    for (int k = 1; k < VW; k++) begin
                        n_stack[k] = r_stack[k-1];
                    end
                    n_count = r_count + 1'b1;
                    n_rem   = '0;
                    n_bit   = '0;
                    if (w_mag_next == '0) begin
                        n_state = S_EMIT;
                    end
                end else begin
                    n_rem = w_rem_next;
                    n_bit = r_bit + 1'b1;
                end
            end
            S_EMIT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    if (r_neg) begin
                        n_out_char = rita_pkg::CH_MINUS;
                        n_out_last = 1'b0;
                        n_neg      = 1'b0;
                    end else begin
                        n_out_char = rita_pkg::digit_to_ascii(r_stack[0]);
                        n_out_last = (r_count == CNT_W'(1));
                        for (int k = 0; k < VW - 1; k++) begin
                            n_stack[k] = r_stack[k+1];
                        end
                        n_count = r_count - 1'b1;
                        if (r_count == CNT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix     <= rita_pkg::RADIX_RESET;
            r_count     <= '0;
            r_neg       <= 1'b0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_radix     <= n_radix;
            r_count     <= n_count;
            r_neg       <= n_neg;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_radix_eff <= n_radix_eff;
        r_mag       <= n_mag;
        r_rem       <= n_rem;
        r_stack     <= n_stack;
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
    end

    `RITA_ASSERT(a_idle_clean, i_clk, i_rst_n, (r_state == S_IDLE) |-> (r_count == '0 && !r_neg))
    `RITA_ASSERT(a_start_div, i_clk, i_rst_n, w_in_acc |=> (r_state == S_DIV && r_bit == '0))
    `RITA_ASSERT(a_stack_room, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_count < CNT_W'(VW)))
    `RITA_ASSERT(a_emit_pending, i_clk, i_rst_n, (r_state == S_EMIT) |-> (r_count != '0))

endmodule
